@@ rtl/jsv_pkg.sv @@
`timescale 1ns / 1ps

package jsv_pkg;

  typedef enum logic [4:0] {
    ST_VALUE         = 5'd0,
    ST_VAL_OR_RBRACK = 5'd1,
    ST_KEY_OR_RBRACE = 5'd2,
    ST_KEY           = 5'd3,
    ST_COLON         = 5'd4,
    ST_AFTER         = 5'd5,
    ST_STR_V         = 5'd6,
    ST_STR_V_ESC     = 5'd7,
    ST_STR_V_HEX     = 5'd8,
    ST_STR_K         = 5'd9,
    ST_STR_K_ESC     = 5'd10,
    ST_STR_K_HEX     = 5'd11,
    ST_LIT_T         = 5'd12,
    ST_LIT_F         = 5'd13,
    ST_LIT_N         = 5'd14,
    ST_NUM_SIGN      = 5'd15,
    ST_NUM_ZERO      = 5'd16,
    ST_NUM_INT       = 5'd17,
    ST_NUM_DOT       = 5'd18,
    ST_NUM_FRAC      = 5'd19,
    ST_NUM_E         = 5'd20,
    ST_NUM_ESIGN     = 5'd21,
    ST_NUM_EXP       = 5'd22
  } parse_state_e;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_SYNTAX = 2'd1,
    VERDICT_DEEP   = 2'd2,
    VERDICT_TRUNC  = 2'd3
  } verdict_e;

  // Stack write request from the parser to the nesting stack.
  typedef struct packed {
    logic push;
    logic obj;
  } stack_op_t;

  // Outcome of parsing one byte.
  typedef struct packed {
    parse_state_e state;
    logic [2:0]   lit;
    stack_op_t    op;
    logic         pop;
    verdict_e     err;   // VERDICT_OK means no error
  } step_t;

  function automatic logic num_accepting(parse_state_e s);
    return (s == ST_NUM_ZERO) || (s == ST_NUM_INT) || (s == ST_NUM_FRAC) ||
           (s == ST_NUM_EXP);
  endfunction

endpackage

@@ rtl/json_syntax_validator_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte, tlast is_last
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata[1:0] verdict, [17:2] bytes_seen
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_data_i[5:0] depth_limit
//
// One byte per cycle, except while a last byte waits on a stalled result. A byte
// is parsed while it sits in the input register and leaves it when consumed;
// the verdict of a last byte is written to the output register at that point.
// The parser loop runs through state, depth and the top-of-stack register.
// Reset clears parser state, counters and valid flags; depth_limit resets to 32.
// The nesting stack needs no clearing. A stalled result holds the next last
// byte in the input register, which then blocks the input; bytes before it flow.

module json_syntax_validator_core import jsv_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [1:0] verdict, [17:2] bytes_seen, [23:18] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i       // [5:0] depth_limit
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W   = (DEPTH_W > 6) ? DEPTH_W : 6;

  // input register
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;

  // parser state
  parse_state_e         state_q, state_d;
  logic [2:0]           lit_q, lit_d;
  logic [DEPTH_W - 1:0] depth_q, depth_d;
  verdict_e             err_q, err_d;
  logic [15:0]          count_q, count_inc;
  logic [5:0]           limit_q;

  // result register
  logic                 out_valid_q;
  verdict_e             out_verdict_q;
  logic [15:0]          out_count_q;

  logic                 consume;
  logic                 parse_en;
  logic                 can_push;
  logic                 top_obj;
  step_t                step;
  stack_op_t            stack_op;
  verdict_e             verdict;

  // A last byte waits in the input register while the result register is full and m_axis_tready is low.
  assign consume       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;
  assign cfg_ready_o   = 1'b1;

  // After the first error, bytes are only counted.
  assign parse_en = consume && (err_q == VERDICT_OK);

  assign can_push = (CMP_W'(depth_q) < CMP_W'(limit_q)) &&
                    (CMP_W'(depth_q) < CMP_W'(MAX_DEPTH));

  assign count_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

  jsv_parse_step u_step (
    .state_i      (state_q),
    .lit_i        (lit_q),
    .byte_i       (in_byte_q),
    .depth_zero_i (depth_q == '0),
    .top_obj_i    (top_obj),
    .can_push_i   (can_push),
    .step_o       (step)
  );

  always_comb begin
    state_d = state_q;
    lit_d   = lit_q;
    depth_d = depth_q;
    err_d   = err_q;
    if (parse_en) begin
      state_d = step.state;
      lit_d   = step.lit;
      err_d   = step.err;
      if (step.op.push) depth_d = depth_q + DEPTH_W'(1);
      else if (step.pop) depth_d = depth_q - DEPTH_W'(1);
    end
  end

  assign stack_op.push = parse_en && step.op.push;
  assign stack_op.obj  = step.op.obj;

  jsv_nest_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .op_i      (stack_op),
    .depth_i   (depth_q),
    .depth_d_i (depth_d),
    .top_obj_o (top_obj)
  );

  // Verdict from the state as it stands after the last byte.
  always_comb begin
    if (err_d != VERDICT_OK) begin
      verdict = err_d;
    end else if ((depth_d == '0) && ((state_d == ST_AFTER) || num_accepting(state_d))) begin
      verdict = VERDICT_OK;
    end else begin
      verdict = VERDICT_TRUNC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Text state; everything returns to its start value after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_VALUE;
      lit_q   <= 3'd0;
      depth_q <= '0;
      err_q   <= VERDICT_OK;
      count_q <= 16'd0;
    end else if (consume && in_last_q) begin
      state_q <= ST_VALUE;
      lit_q   <= 3'd0;
      depth_q <= '0;
      err_q   <= VERDICT_OK;
      count_q <= 16'd0;
    end else if (consume) begin
      state_q <= state_d;
      lit_q   <= lit_d;
      depth_q <= depth_d;
      err_q   <= err_d;
      count_q <= count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_verdict_q <= verdict;
      out_count_q   <= count_inc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_verdict_q};

endmodule

@@ rtl/jsv_parse_step.sv @@
`timescale 1ns / 1ps

module jsv_parse_step import jsv_pkg::*; (
  input  parse_state_e state_i,
  input  logic [2:0]   lit_i,
  input  logic [7:0]   byte_i,
  input  logic         depth_zero_i,
  input  logic         top_obj_i,
  input  logic         can_push_i,
  output step_t        step_o
);

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [7:0] word_char(parse_state_e s, logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (s)
      ST_LIT_T: begin
        case (i)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      ST_LIT_F: begin
        case (i)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (i)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic step_t f_close(step_t s, logic obj, logic dz, logic top);
    step_t r;
    r = s;
    if (dz || (top != obj)) begin
      r.err = VERDICT_SYNTAX;
    end else begin
      r.pop   = 1'b1;
      r.state = ST_AFTER;
    end
    return r;
  endfunction

  function automatic step_t f_open(step_t s, logic obj, logic ok);
    step_t r;
    r = s;
    if (!ok) begin
      r.err = VERDICT_DEEP;
    end else begin
      r.op.push = 1'b1;
      r.op.obj  = obj;
      r.state   = obj ? ST_KEY_OR_RBRACE : ST_VAL_OR_RBRACK;
    end
    return r;
  endfunction

  function automatic step_t f_after(step_t s, logic [7:0] c, logic dz, logic top);
    step_t r;
    r = s;
    if (is_ws(c)) begin
      r = s;
    end else if (c == "]") begin
      r = f_close(s, 1'b0, dz, top);
    end else if (c == "}") begin
      r = f_close(s, 1'b1, dz, top);
    end else if ((c == ",") && !dz) begin
      r.state = top ? ST_KEY : ST_VALUE;
    end else begin
      r.err = VERDICT_SYNTAX;
    end
    return r;
  endfunction

  function automatic step_t f_start(step_t s, logic [7:0] c, logic ok);
    step_t r;
    r = s;
    r.lit = 3'd1;
    if (c == 8'h22)       r.state = ST_STR_V;
    else if (c == "t")    r.state = ST_LIT_T;
    else if (c == "f")    r.state = ST_LIT_F;
    else if (c == "n")    r.state = ST_LIT_N;
    else if (c == "-")    r.state = ST_NUM_SIGN;
    else if (c == "0")    r.state = ST_NUM_ZERO;
    else if (is_dig(c))   r.state = ST_NUM_INT;
    else if (c == "[")    r = f_open(r, 1'b0, ok);
    else if (c == "{")    r = f_open(r, 1'b1, ok);
    else                  r.err = VERDICT_SYNTAX;
    return r;
  endfunction

  step_t      base;
  step_t      num_exit;
  logic [2:0] lit_inc;
  logic [2:0] lit_len;
  logic       is_e;
  logic       is_key;

  assign lit_inc = lit_i + 3'd1;
  assign lit_len = (state_i == ST_LIT_F) ? 3'd5 : 3'd4;
  assign is_e    = (byte_i == "e") || (byte_i == "E");
  assign is_key  = (state_i == ST_STR_K) || (state_i == ST_STR_K_ESC) ||
                   (state_i == ST_STR_K_HEX);

  always_comb begin
    base = '{state: state_i, lit: lit_i, op: '0, pop: 1'b0, err: VERDICT_OK};
  end

  // A number ends on the first byte that cannot extend it; if the number is
  // complete, that byte is taken as the byte after a value, else it is a syntax error.
  always_comb begin
    num_exit = base;
    if (num_accepting(state_i)) begin
      num_exit.state = ST_AFTER;
      num_exit = f_after(num_exit, byte_i, depth_zero_i, top_obj_i);
    end else begin
      num_exit.err = VERDICT_SYNTAX;
    end
  end

  always_comb begin
    step_o = base;
    unique case (state_i)
      ST_STR_V, ST_STR_K: begin
        if (byte_i == 8'h22) step_o.state = is_key ? ST_COLON : ST_AFTER;
        else if (byte_i == 8'h5C) step_o.state = is_key ? ST_STR_K_ESC : ST_STR_V_ESC;
        else if (byte_i < 8'h20) step_o.err = VERDICT_SYNTAX;
      end
      ST_STR_V_ESC, ST_STR_K_ESC: begin
        if ((byte_i == 8'h22) || (byte_i == 8'h5C) || (byte_i == "/") ||
            (byte_i == "b") || (byte_i == "f") || (byte_i == "n") ||
            (byte_i == "r") || (byte_i == "t")) begin
          step_o.state = is_key ? ST_STR_K : ST_STR_V;
        end else if (byte_i == "u") begin
          step_o.lit   = 3'd0;
          step_o.state = is_key ? ST_STR_K_HEX : ST_STR_V_HEX;
        end else begin
          step_o.err = VERDICT_SYNTAX;
        end
      end
      ST_STR_V_HEX, ST_STR_K_HEX: begin
        if (!is_hex(byte_i)) begin
          step_o.err = VERDICT_SYNTAX;
        end else begin
          step_o.lit = lit_inc;
          if (lit_inc >= 3'd4) step_o.state = is_key ? ST_STR_K : ST_STR_V;
        end
      end
      ST_LIT_T, ST_LIT_F, ST_LIT_N: begin
        if ((lit_i >= lit_len) || (byte_i != word_char(state_i, lit_i))) begin
          step_o.err = VERDICT_SYNTAX;
        end else begin
          step_o.lit = lit_inc;
          if (lit_inc == lit_len) step_o.state = ST_AFTER;
        end
      end
      ST_NUM_SIGN: begin
        if (byte_i == "0")       step_o.state = ST_NUM_ZERO;
        else if (is_dig(byte_i)) step_o.state = ST_NUM_INT;
        else                     step_o = num_exit;
      end
      ST_NUM_ZERO, ST_NUM_INT: begin
        if ((state_i == ST_NUM_INT) && is_dig(byte_i)) step_o = base;
        else if (byte_i == ".")                         step_o.state = ST_NUM_DOT;
        else if (is_e)                                  step_o.state = ST_NUM_E;
        else                                            step_o = num_exit;
      end
      ST_NUM_DOT: begin
        if (is_dig(byte_i)) step_o.state = ST_NUM_FRAC;
        else                step_o = num_exit;
      end
      ST_NUM_FRAC: begin
        if (is_dig(byte_i)) step_o = base;
        else if (is_e)      step_o.state = ST_NUM_E;
        else                step_o = num_exit;
      end
      ST_NUM_E: begin
        if ((byte_i == "+") || (byte_i == "-")) step_o.state = ST_NUM_ESIGN;
        else if (is_dig(byte_i))                step_o.state = ST_NUM_EXP;
        else                                    step_o = num_exit;
      end
      ST_NUM_ESIGN: begin
        if (is_dig(byte_i)) step_o.state = ST_NUM_EXP;
        else                step_o = num_exit;
      end
      ST_NUM_EXP: begin
        if (is_dig(byte_i)) step_o = base;
        else                step_o = num_exit;
      end
      ST_AFTER: begin
        step_o = f_after(base, byte_i, depth_zero_i, top_obj_i);
      end
      ST_VALUE: begin
        if (!is_ws(byte_i)) step_o = f_start(base, byte_i, can_push_i);
      end
      ST_VAL_OR_RBRACK: begin
        if (is_ws(byte_i))       step_o = base;
        else if (byte_i == "]")  step_o = f_close(base, 1'b0, depth_zero_i, top_obj_i);
        else                     step_o = f_start(base, byte_i, can_push_i);
      end
      ST_KEY_OR_RBRACE: begin
        if (is_ws(byte_i))         step_o = base;
        else if (byte_i == "}")    step_o = f_close(base, 1'b1, depth_zero_i, top_obj_i);
        else if (byte_i == 8'h22)  step_o.state = ST_STR_K;
        else                       step_o.err = VERDICT_SYNTAX;
      end
      ST_KEY: begin
        if (is_ws(byte_i))         step_o = base;
        else if (byte_i == 8'h22)  step_o.state = ST_STR_K;
        else                       step_o.err = VERDICT_SYNTAX;
      end
      ST_COLON: begin
        if (is_ws(byte_i))       step_o = base;
        else if (byte_i == ":")  step_o.state = ST_VALUE;
        else                     step_o.err = VERDICT_SYNTAX;
      end
      default: begin
        step_o.err = VERDICT_SYNTAX;
      end
    endcase
  end

endmodule

@@ rtl/jsv_nest_stack.sv @@
`timescale 1ns / 1ps

// One bit per open container (1 = object). The top entry is kept in a
// register that is refreshed every cycle from the depth about to be in force;
// a push forwards its own bit.
module jsv_nest_stack import jsv_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  stack_op_t                            op_i,
  input  logic [$clog2(MAX_DEPTH + 1) - 1:0]   depth_i,
  input  logic [$clog2(MAX_DEPTH + 1) - 1:0]   depth_d_i,
  output logic                                 top_obj_o
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic                 mem [MAX_DEPTH];
  logic                 top_q;
  logic [DEPTH_W - 1:0] rd_ptr;
  logic [AW - 1:0]      rd_addr;
  logic [AW - 1:0]      wr_addr;

  assign rd_ptr  = depth_d_i - DEPTH_W'(1);
  assign rd_addr = rd_ptr[AW - 1:0];
  assign wr_addr = depth_i[AW - 1:0];

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      mem[wr_addr] <= op_i.obj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      top_q <= op_i.obj;
    end else begin
      top_q <= mem[rd_addr];
    end
  end

  assign top_obj_o = top_q;

endmodule

@@ rtl/jsv_checker.sv @@
`timescale 1ns / 1ps

module jsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [5:0]  cfg_data_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A text has at least its last byte.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:2] != 16'd0)
    else $error("result with zero byte count");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
    else $error("nonzero padding in result");

  // A new result needs an earlier last-byte transfer or an earlier input stall.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && $past(rst_ni, 2) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2) ||
      $past(!s_axis_tready, 2))
    else $error("result without a last byte");

  // The configuration register is always writable.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind json_syntax_validator_core jsv_checker u_jsv_checker (.*);
